/* rtl/isas_pkg.sv */
// ----------------------------------------------------------------------------
// isas_pkg: shared types and constants of the indexed shift array store
// Store geometry, operation and status codes, and the command that is
// broadcast to the row of storage cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package isas_pkg;

  localparam int unsigned CAPACITY   = 32;
  localparam int unsigned WORD_WIDTH = 32;

  localparam int unsigned IDX_W  = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W  = 6;
  localparam int unsigned CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned FILL_W = 6;
  localparam int unsigned WIDE_W = (WORD_WIDTH > DATA_W) ? WORD_WIDTH : DATA_W;

  typedef logic [WORD_WIDTH-1:0] word_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_ERASE  = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_INSERT = 2'd2,
    ACT_ERASE  = 2'd3
  } act_e;

  // broadcast to every cell
  typedef struct packed {
    act_e  act;
    idx_t  tgt;
    word_t word;
  } cmd_t;

  // per-transaction outcome from the decoder
  typedef struct packed {
    status_e status;
    logic    rd_en;
    cnt_t    count_d;
  } res_t;

  function automatic word_t to_word(logic [DATA_W-1:0] v);
    logic [WIDE_W-1:0] t;
    t = WIDE_W'(v);
    return t[WORD_WIDTH-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] to_out(word_t w);
    logic [WIDE_W-1:0] t;
    t = WIDE_W'(w);
    return t[DATA_W-1:0];
  endfunction

endpackage

/* rtl/isas_cell.sv */
// ----------------------------------------------------------------------------
// isas_cell: one storage cell of the shift array
// Holds one entry; loads the broadcast word, takes its lower neighbor on an
// insert above the target, or its upper neighbor on an erase at or above it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module isas_cell (
  input  logic                 clk_i,
  input  isas_pkg::idx_t       idx_i,
  input  isas_pkg::cmd_t       cmd_i,
  input  isas_pkg::word_t      lower_i,
  input  isas_pkg::word_t      upper_i,
  output isas_pkg::word_t      word_o
);

  isas_pkg::word_t word_q, word_d;
  logic            at_tgt, above_tgt;

  assign at_tgt    = (idx_i == cmd_i.tgt);
  assign above_tgt = (idx_i > cmd_i.tgt);

  always_comb begin
    word_d = word_q;
    case (cmd_i.act)
      isas_pkg::ACT_APPEND: begin
        if (at_tgt) word_d = cmd_i.word;
      end
      isas_pkg::ACT_INSERT: begin
        if (at_tgt) word_d = cmd_i.word;
        else if (above_tgt) word_d = lower_i;
      end
      isas_pkg::ACT_ERASE: begin
        if (at_tgt || above_tgt) word_d = upper_i;
      end
      default: word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

/* rtl/isas_ctrl.sv */
// ----------------------------------------------------------------------------
// isas_ctrl: request decoder of the shift array
// Checks position against the fill count, picks the cell action and target,
// and gives status, read enable and the next fill count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module isas_ctrl (
  input  logic                          accept_i,
  input  logic [1:0]                    op_i,
  input  logic [isas_pkg::POS_W-1:0]    position_i,
  input  isas_pkg::word_t               word_i,
  input  isas_pkg::cnt_t                count_i,
  output isas_pkg::cmd_t                cmd_o,
  output isas_pkg::res_t                res_o
);

  logic [isas_pkg::CMP_W-1:0] pos_w, cnt_w;
  logic                       full;
  isas_pkg::op_e              op;

  assign op    = isas_pkg::op_e'(op_i);
  assign pos_w = isas_pkg::CMP_W'(position_i);
  assign cnt_w = isas_pkg::CMP_W'(count_i);
  assign full  = (count_i == isas_pkg::CNT_W'(isas_pkg::CAPACITY));

  always_comb begin
    cmd_o.act     = isas_pkg::ACT_NONE;
    cmd_o.tgt     = isas_pkg::IDX_W'(position_i);
    cmd_o.word    = word_i;
    res_o.status  = isas_pkg::ST_DONE;
    res_o.rd_en   = 1'b0;
    res_o.count_d = count_i;
    case (op)
      isas_pkg::OP_APPEND: begin
        if (full) begin
          res_o.status = isas_pkg::ST_FULL;
        end else begin
          cmd_o.act     = isas_pkg::ACT_APPEND;
          cmd_o.tgt     = isas_pkg::IDX_W'(count_i);
          res_o.count_d = count_i + 1'b1;
        end
      end
      isas_pkg::OP_INSERT: begin
        // range check wins over the full check
        if (pos_w > cnt_w) begin
          res_o.status = isas_pkg::ST_RANGE;
        end else if (full) begin
          res_o.status = isas_pkg::ST_FULL;
        end else begin
          cmd_o.act     = isas_pkg::ACT_INSERT;
          res_o.count_d = count_i + 1'b1;
        end
      end
      isas_pkg::OP_ERASE: begin
        if (pos_w >= cnt_w) begin
          res_o.status = isas_pkg::ST_RANGE;
        end else begin
          cmd_o.act     = isas_pkg::ACT_ERASE;
          res_o.count_d = count_i - 1'b1;
        end
      end
      default: begin
        if (pos_w >= cnt_w) res_o.status = isas_pkg::ST_RANGE;
        else res_o.rd_en = 1'b1;
      end
    endcase
    if (!accept_i) cmd_o.act = isas_pkg::ACT_NONE;
  end

endmodule

/* rtl/indexed_shift_array_store.sv */
// ----------------------------------------------------------------------------
// indexed_shift_array_store: ordered store of signed words in a cell row
// An accepted request's result is registered. Throughput: one request per
// cycle unless the output stalls, since every cell shifts or loads in the
// same cycle as its neighbors. Reset clears the fill count and the output
// valid; entries hold no defined value until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module indexed_shift_array_store (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           op_i,
  input  logic [5:0]           position_i,
  input  logic signed [31:0]   item_value_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [31:0]   read_word_o,
  output logic [1:0]           status_o,
  output logic [5:0]           fill_count_o
);

  localparam int unsigned N = isas_pkg::CAPACITY;

  logic                 acc;
  logic                 out_valid_q;
  logic [31:0]          read_word_q, read_word_d;
  logic [1:0]           status_q;
  logic [5:0]           fill_q;
  isas_pkg::cnt_t       count_q;
  isas_pkg::cmd_t       cmd;
  isas_pkg::res_t       res;
  isas_pkg::word_t      cell_word [N];

  assign in_stall_o = out_valid_q & out_stall_i;
  assign acc        = in_valid_i & ~in_stall_o;

  isas_ctrl u_ctrl (
    .accept_i   (acc),
    .op_i       (op_i),
    .position_i (position_i),
    .word_i     (isas_pkg::to_word($unsigned(item_value_i))),
    .count_i    (count_q),
    .cmd_o      (cmd),
    .res_o      (res)
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    isas_pkg::word_t lower, upper;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = cell_word[i-1];
    end
    if (i == N - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = cell_word[i+1];
    end
    isas_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (isas_pkg::IDX_W'(i)),
      .cmd_i   (cmd),
      .lower_i (lower),
      .upper_i (upper),
      .word_o  (cell_word[i])
    );
  end

  // read port only looked at on an in-range read
  assign read_word_d = res.rd_en
                     ? isas_pkg::to_out(cell_word[isas_pkg::IDX_W'(position_i)])
                     : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      if (acc) begin
        out_valid_q <= 1'b1;
        count_q     <= res.count_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      read_word_q <= read_word_d;
      status_q    <= res.status;
      fill_q      <= 6'(res.count_d);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_word_o  = $signed(read_word_q);
  assign status_o     = status_q;
  assign fill_count_o = fill_q;

`ifndef ASSERT_OFF
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= isas_pkg::CNT_W'(isas_pkg::CAPACITY))
    else $error("fill count exceeds capacity");

  a_reject_keeps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && res.status != isas_pkg::ST_DONE) |=> (count_q == $past(count_q)))
    else $error("rejected transaction changed the fill count");

  a_reject_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !res.rd_en) |=> (read_word_q == '0))
    else $error("read word not zero for a non-read transaction");

  a_append_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && cmd.act == isas_pkg::ACT_APPEND) |=> (count_q == $past(count_q) + 1'b1))
    else $error("append did not grow the fill count");
`endif

endmodule
